@@ design/spi_slave_word_access_crc8_assert.svh @@
// Assertion macros for the SPI word access checker.
// No dependencies; included by the checker file.
`ifndef SPI_SLAVE_WORD_ACCESS_CRC8_ASSERT_SVH
`define SPI_SLAVE_WORD_ACCESS_CRC8_ASSERT_SVH

// same-cycle implication
`define SSWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sswa_pkg.sv @@
// Package for the SPI slave word access engine: sizes, register indexes,
// frame phases, controller commands and the CRC-8 step function.
package sswa_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int WORD_BYTES  = 4;

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RO_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 3'd4;

    localparam logic       RST_CRC_EN     = 1'b1;
    localparam logic [7:0] RST_READ_CODE  = 8'd1;
    localparam logic [7:0] RST_WRITE_CODE = 8'd2;
    localparam logic [7:0] RST_RO_LIMIT   = 8'd0;
    localparam logic [7:0] RST_CRC_POLY   = 8'd7;

    typedef enum logic [2:0] {
        PH_CMD  = 3'd0,
        PH_ADDR = 3'd1,
        PH_DATA = 3'd2,
        PH_CRC  = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    typedef struct packed {
        logic latch;
        logic exec;
    } ctrl_cmd_t;

    // MSB-first CRC-8, init taken from crc
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ design/sswa_if.sv @@
// Channel interfaces: received byte transfers and response transfers.
// No dependencies.
interface sswa_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface sswa_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       write_done;

    modport source (output valid, output tx_load, output tx_byte, output write_done,
                    input ready);
    modport sink   (input valid, input tx_load, input tx_byte, input write_done,
                    output ready);
endinterface

@@ design/sswa_ctrl.sv @@
// Handshake controller: takes one transfer, runs it, holds the response.
// Depends on sswa_pkg.
module sswa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sswa_pkg::ctrl_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   exec;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign exec      = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    assign cmd.latch = in_valid && in_ready;
    assign cmd.exec  = exec;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/sswa_dp.sv @@
// Datapath: config registers, frame state, word store, CRC-8 and response regs.
// Depends on sswa_pkg.
module sswa_dp
#(
    parameter int STORE_DEPTH = sswa_pkg::STORE_DEPTH,
    parameter int WORD_BYTES  = sswa_pkg::WORD_BYTES
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  sswa_pkg::ctrl_cmd_t            cmd,
    input  logic                           command,
    input  logic [7:0]                     rx_byte,
    input  logic                           cfg_we,
    input  logic [sswa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sswa_pkg::CFG_W-1:0]     cfg_data,
    output logic                           tx_load,
    output logic [7:0]                     tx_byte,
    output logic                           write_done
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int WORD_W = 8 * WORD_BYTES;
    localparam int CNT_W  = $clog2(WORD_BYTES + 1);
    localparam int BI_W   = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
    localparam logic [8:0]       DEPTH_C = 9'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] WB_C    = CNT_W'(WORD_BYTES);

    // configuration
    logic       crc_en_reg;
    logic [7:0] read_code_reg;
    logic [7:0] write_code_reg;
    logic [7:0] ro_limit_reg;
    logic [7:0] poly_reg;

    // latched transfer
    logic       cmd_in_reg;
    logic [7:0] rx_reg;

    // frame state
    sswa_pkg::phase_t                phase_reg, phase_next;
    logic [7:0]                      fcmd_reg, fcmd_next;
    logic [7:0]                      addr_reg, addr_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [7:0]                      crc_reg, crc_next;
    logic [WORD_BYTES-1:0][7:0]      buf_reg, buf_next;

    // store
    logic [WORD_W-1:0]      mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [WORD_W-1:0]      rdata_reg;
    logic                   rvalid_reg;
    logic                   mem_we;

    // response
    logic       tx_load_reg, load;
    logic [7:0] tx_byte_reg, tx;
    logic       done_reg, done;

    logic                       is_read;
    logic                       is_write;
    logic [WORD_BYTES-1:0][7:0] rd_word;
    logic [7:0]                 byte_sel;
    logic [7:0]                 crc_src;
    logic                       crc_add;
    logic [7:0]                 crc_stepped;
    logic                       rx_in_range;
    logic                       addr_in_range;

    assign is_read       = (fcmd_reg == read_code_reg);
    assign is_write      = !is_read && (fcmd_reg == write_code_reg);
    assign rx_in_range   = ({1'b0, rx_reg} < DEPTH_C);
    assign addr_in_range = ({1'b0, addr_reg} < DEPTH_C);
    assign rd_word       = (rx_in_range && rvalid_reg) ? rdata_reg : '0;
    assign byte_sel      = buf_reg[cnt_reg[BI_W-1:0]];
    assign crc_stepped   = sswa_pkg::crc8_step(crc_reg, crc_src, poly_reg);

    always_comb
    begin
        phase_next = phase_reg;
        fcmd_next  = fcmd_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        buf_next   = buf_reg;
        crc_src    = rx_reg;
        crc_add    = 1'b0;
        load       = 1'b0;
        tx         = 8'd0;
        done       = 1'b0;
        mem_we     = 1'b0;

        if (cmd_in_reg)
        begin
            phase_next = sswa_pkg::PH_CMD;
            fcmd_next  = 8'd0;
            cnt_next   = '0;
        end
        else
        begin
            case (phase_reg)
                sswa_pkg::PH_CMD:
                begin
                    fcmd_next  = rx_reg;
                    tx         = rx_reg;
                    load       = 1'b1;
                    crc_add    = 1'b1;
                    phase_next = sswa_pkg::PH_ADDR;
                end
                sswa_pkg::PH_ADDR:
                begin
                    addr_next = rx_reg;
                    if (is_read)
                    begin
                        buf_next = rd_word;
                        tx       = rd_word[0];
                        crc_src  = rd_word[0];
                        cnt_next = CNT_W'(1);
                    end
                    else
                    begin
                        tx = rx_reg;
                    end
                    load       = 1'b1;
                    crc_add    = 1'b1;
                    phase_next = sswa_pkg::PH_DATA;
                end
                sswa_pkg::PH_DATA:
                begin
                    if (cnt_reg < WB_C)
                    begin
                        if (is_read)
                        begin
                            tx       = byte_sel;
                            crc_src  = byte_sel;
                            crc_add  = 1'b1;
                            load     = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        else if (is_write)
                        begin
                            crc_add  = 1'b1;
                            tx       = crc_en_reg ? crc_stepped : 8'd0;
                            load     = 1'b1;
                            buf_next[cnt_reg[BI_W-1:0]] = rx_reg;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    if (cnt_next >= WB_C)
                    begin
                        if (is_write)
                        begin
                            if ((addr_reg > ro_limit_reg) && addr_in_range)
                            begin
                                mem_we = 1'b1;
                                done   = 1'b1;
                            end
                            if (crc_en_reg)
                            begin
                                tx   = crc_add ? crc_stepped : crc_reg;
                                load = 1'b1;
                            end
                            phase_next = sswa_pkg::PH_DONE;
                        end
                        else if (is_read)
                        begin
                            phase_next = crc_en_reg ? sswa_pkg::PH_CRC : sswa_pkg::PH_DONE;
                        end
                    end
                end
                sswa_pkg::PH_CRC:
                begin
                    tx         = crc_reg;
                    load       = 1'b1;
                    phase_next = sswa_pkg::PH_DONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd_in_reg)
        begin
            crc_next = 8'd0;
        end
        else if (crc_add && crc_en_reg)
        begin
            crc_next = crc_stepped;
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg     <= sswa_pkg::RST_CRC_EN;
            read_code_reg  <= sswa_pkg::RST_READ_CODE;
            write_code_reg <= sswa_pkg::RST_WRITE_CODE;
            ro_limit_reg   <= sswa_pkg::RST_RO_LIMIT;
            poly_reg       <= sswa_pkg::RST_CRC_POLY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sswa_pkg::CFG_CRC_EN:     crc_en_reg     <= cfg_data[0];
                sswa_pkg::CFG_READ_CODE:  read_code_reg  <= cfg_data;
                sswa_pkg::CFG_WRITE_CODE: write_code_reg <= cfg_data;
                sswa_pkg::CFG_RO_LIMIT:   ro_limit_reg   <= cfg_data;
                sswa_pkg::CFG_CRC_POLY:   poly_reg       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sswa_pkg::PH_CMD;
            fcmd_reg  <= 8'd0;
            addr_reg  <= 8'd0;
            cnt_reg   <= '0;
            crc_reg   <= 8'd0;
            valid_reg <= '0;
        end
        else if (cmd.exec)
        begin
            phase_reg <= phase_next;
            fcmd_reg  <= fcmd_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            if (mem_we)
            begin
                valid_reg[addr_reg[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_in_reg <= command;
            rx_reg     <= rx_byte;
            rdata_reg  <= mem[rx_byte[ADDR_W-1:0]];
            rvalid_reg <= valid_reg[rx_byte[ADDR_W-1:0]];
        end
        if (cmd.exec)
        begin
            buf_reg     <= buf_next;
            tx_load_reg <= load;
            tx_byte_reg <= tx;
            done_reg    <= done;
            if (mem_we)
            begin
                mem[addr_reg[ADDR_W-1:0]] <= buf_next;
            end
        end
    end

    assign tx_load    = tx_load_reg;
    assign tx_byte    = tx_byte_reg;
    assign write_done = done_reg;

endmodule

@@ design/spi_slave_word_access_crc8.sv @@
// SPI slave word access engine with running CRC-8, top level.
// The byte transfer is latched, executed in the EXEC state and the response registered;
// execution waits only while an earlier response still waits on the output.
// A new transfer is not taken until the current one has been executed.
// A pending response does not block the next transfer from being taken.
// Reset: asynchronous, active low; store valid bits clear at once, no clearing pass.
module spi_slave_word_access_crc8
#(
    parameter int STORE_DEPTH = sswa_pkg::STORE_DEPTH,
    parameter int WORD_BYTES  = sswa_pkg::WORD_BYTES
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    sswa_req_if.sink                       req,
    sswa_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [sswa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sswa_pkg::CFG_W-1:0]     cfg_data
);

    sswa_pkg::ctrl_cmd_t cmd;

    sswa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    sswa_dp
    #(
        .STORE_DEPTH (STORE_DEPTH),
        .WORD_BYTES  (WORD_BYTES)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .command    (req.command),
        .rx_byte    (req.rx_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tx_load    (rsp.tx_load),
        .tx_byte    (rsp.tx_byte),
        .write_done (rsp.write_done)
    );

endmodule

@@ design/sswa_chk.sv @@
// Port-level checker for the SPI word access engine, bound to the top level.
// Depends on spi_slave_word_access_crc8_assert.svh.
`include "spi_slave_word_access_crc8_assert.svh"

module sswa_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_tx_load,
    input logic [7:0] rsp_tx_byte,
    input logic       rsp_write_done
);

    `SSWA_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_tx_load) && $stable(rsp_write_done), "stalled response changed")

    `SSWA_ASSERT_NXT(a_busy_after_transfer, clk, rst_n, req_valid && req_ready, !req_ready, "transfer taken while busy")

    `SSWA_ASSERT_IMP(a_rsp_from_exec, clk, rst_n, $rose(rsp_valid), $past(!req_ready), "response without a transfer")

    `SSWA_ASSERT_IMP(a_done_loads, clk, rst_n, rsp_valid && (rsp_write_done || !rsp_tx_load), (rsp_tx_load || rsp_tx_byte == 8'd0) && (!rsp_write_done || rsp_tx_load), "bad response byte")

endmodule

bind spi_slave_word_access_crc8 sswa_chk u_sswa_chk
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_tx_load    (rsp.tx_load),
    .rsp_tx_byte    (rsp.tx_byte),
    .rsp_write_done (rsp.write_done)
);

@@ tb/spi_frame_check.sv @@
`timescale 1ns / 100ps
// Frame checker for the SPI slave word access engine: predicts each response from
// the received byte transfers and compares it. Depends on sswa_pkg and sswa_if.
module spi_frame_check
    import sswa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    sswa_req_if                  req,
    sswa_rsp_if                  rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic       load;
        logic [7:0] data;
        logic       done;
    } tx_resp_t;

    logic       crc_en;
    logic [7:0] rd_code;
    logic [7:0] wr_code;
    logic [7:0] ro_limit;
    logic [7:0] poly;

    phase_t     frm_phase;
    logic [7:0] frm_cmd;
    logic [7:0] frm_addr;
    int         nbytes;
    logic [7:0] crc;
    logic [8*WORD_BYTES-1:0] word_buf;
    logic [8*WORD_BYTES-1:0] word_mem [STORE_DEPTH];

    tx_resp_t   tx_expected [$];

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            r = r[7] ? ({r[6:0], 1'b0} ^ poly) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic void fold_crc(input logic [7:0] b);
        if (crc_en)
            crc = crc8_next(crc, b);
    endfunction

    function automatic tx_resp_t predict_transfer(input logic cs_release, input logic [7:0] b);
        tx_resp_t r;
        logic     is_rd;
        logic     is_wr;
        r = '0;
        is_rd = (frm_cmd == rd_code);
        is_wr = !is_rd && (frm_cmd == wr_code);
        if (cs_release)
        begin
            frm_phase = PH_CMD;
            frm_cmd   = '0;
            nbytes    = 0;
            crc       = '0;
        end
        else
        begin
            case (frm_phase)
                PH_CMD:
                begin
                    frm_cmd   = b;
                    r.load    = 1'b1;
                    r.data    = b;
                    fold_crc(b);
                    frm_phase = PH_ADDR;
                end
                PH_ADDR:
                begin
                    frm_addr = b;
                    r.load   = 1'b1;
                    if (is_rd)
                    begin
                        word_buf = (int'(b) < STORE_DEPTH) ? word_mem[b] : '0;
                        r.data   = word_buf[7:0];
                        fold_crc(r.data);
                        nbytes   = 1;
                    end
                    else
                    begin
                        fold_crc(b);
                        r.data = b;
                    end
                    frm_phase = PH_DATA;
                end
                PH_DATA:
                begin
                    if (nbytes < WORD_BYTES)
                    begin
                        if (is_rd)
                        begin
                            r.load = 1'b1;
                            r.data = word_buf[8*nbytes +: 8];
                            fold_crc(r.data);
                            nbytes++;
                        end
                        else if (is_wr)
                        begin
                            fold_crc(b);
                            r.load = 1'b1;
                            r.data = crc_en ? crc : 8'h00;
                            word_buf[8*nbytes +: 8] = b;
                            nbytes++;
                        end
                    end
                    if (nbytes >= WORD_BYTES)
                    begin
                        if (is_wr)
                        begin
                            if (frm_addr > ro_limit && int'(frm_addr) < STORE_DEPTH)
                            begin
                                word_mem[frm_addr] = word_buf;
                                r.done = 1'b1;
                            end
                            if (crc_en)
                            begin
                                r.load = 1'b1;
                                r.data = crc;
                            end
                            frm_phase = PH_DONE;
                        end
                        else if (is_rd)
                            frm_phase = crc_en ? PH_CRC : PH_DONE;
                    end
                end
                PH_CRC:
                begin
                    r.load    = 1'b1;
                    r.data    = crc;
                    frm_phase = PH_DONE;
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (fail_count < 200)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : watch
        tx_resp_t got;
        tx_resp_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            crc_en     = RST_CRC_EN;
            rd_code    = RST_READ_CODE;
            wr_code    = RST_WRITE_CODE;
            ro_limit   = RST_RO_LIMIT;
            poly       = RST_CRC_POLY;
            frm_phase  = PH_CMD;
            frm_cmd    = '0;
            frm_addr   = '0;
            nbytes     = 0;
            crc        = '0;
            word_buf   = '0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                word_mem[i] = '0;
            end
            tx_expected.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CRC_EN:     crc_en   = cfg_data[0];
                    CFG_READ_CODE:  rd_code  = cfg_data;
                    CFG_WRITE_CODE: wr_code  = cfg_data;
                    CFG_RO_LIMIT:   ro_limit = cfg_data;
                    CFG_CRC_POLY:   poly     = cfg_data;
                    default:        ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                got = '{load: rsp.tx_load, data: rsp.tx_byte, done: rsp.write_done};
                if (tx_expected.size() == 0)
                    report_mismatch("unexpected response transfer", 0, got);
                else
                begin
                    want = tx_expected.pop_front();
                    if (got.load !== want.load)
                        report_mismatch("tx_load", want.load, got.load);
                    if (got.data !== want.data)
                        report_mismatch("tx_byte", want.data, got.data);
                    if (got.done !== want.done)
                        report_mismatch("write_done", want.done, got.done);
                end
            end
            if (req.valid && req.ready)
                tx_expected.push_back(predict_transfer(req.command, req.rx_byte));
        end
        pending = tx_expected.size();
    end

endmodule

@@ tb/tb_spi_slave_word_access_crc8.sv @@
`timescale 1ns / 100ps
// Testbench top for spi_slave_word_access_crc8: drives byte transfers, frames and
// register settings. Depends on sswa_pkg, sswa_if and spi_frame_check.
module tb_spi_slave_word_access_crc8;
    import sswa_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;

    sswa_req_if req ();
    sswa_rsp_if rsp ();

    logic       cur_en;
    logic [7:0] cur_rd;
    logic [7:0] cur_wr;
    logic [7:0] cur_lim;
    int         sent;
    bit         quiet = 1'b0;
    int         hold_left = 0;

    spi_slave_word_access_crc8 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    spi_frame_check frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("tb_spi_slave_word_access_crc8 failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // response side back-pressure
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left = hold_left - 1;
        else if (!quiet && $urandom_range(0, 3) == 0)
            hold_left = pick_gap() + 1;
        rsp.ready <= (hold_left == 0);
    end

    task automatic send_byte(input logic cs_release, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.command <= cs_release;
        req.rx_byte <= b;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic en, input logic [7:0] rd, input logic [7:0] wr,
                                  input logic [7:0] lim, input logic [7:0] poly);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CRC_EN;
        cfg_data  <= {7'd0, en};
        @(posedge clk);
        cfg_index <= CFG_READ_CODE;
        cfg_data  <= rd;
        @(posedge clk);
        cfg_index <= CFG_WRITE_CODE;
        cfg_data  <= wr;
        @(posedge clk);
        cfg_index <= CFG_RO_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_index <= CFG_CRC_POLY;
        cfg_data  <= poly;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_en  = en;
        cur_rd  = rd;
        cur_wr  = wr;
        cur_lim = lim;
    endtask

    function automatic logic [7:0] pick_address();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return cur_lim;
            3:       return cur_lim + 8'd1;
            4, 5, 6: return 8'($urandom_range(0, 15));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_frame();
        int         kind;
        int         n_after;
        logic [7:0] code;
        kind  = $urandom_range(0, 99);
        quiet = ($urandom_range(0, 7) == 0);
        if (kind >= 92)
        begin
            // noise, sometimes without a deselect in front
            repeat ($urandom_range(1, 6))
                send_byte($urandom_range(0, 4) == 0, 8'($urandom));
            return;
        end
        send_byte(1'b1, 8'($urandom));
        if (kind < 42)
        begin
            code    = cur_rd;
            n_after = WORD_BYTES + (cur_en ? 1 : 0);
        end
        else if (kind < 84)
        begin
            code    = cur_wr;
            n_after = WORD_BYTES;
        end
        else
        begin
            do
                code = 8'($urandom_range(0, 255));
            while (code == cur_rd || code == cur_wr);
            n_after = $urandom_range(0, 3);
        end
        if ($urandom_range(0, 99) < 12)
            n_after = $urandom_range(0, n_after);
        else if ($urandom_range(0, 99) < 20)
            n_after += $urandom_range(1, 3);
        send_byte(1'b0, code);
        if ($urandom_range(0, 49) == 0)
            return;
        send_byte(1'b0, pick_address());
        repeat (n_after)
            send_byte(1'b0, 8'($urandom));
    endtask

    initial
    begin
        int wait_cnt;
        int goal;
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.command = 1'b0;
        req.rx_byte = 8'h00;
        cfg_we      = 1'b0;
        cfg_index   = CFG_CRC_EN;
        cfg_data    = '0;
        cur_en      = RST_CRC_EN;
        cur_rd      = RST_READ_CODE;
        cur_wr      = RST_WRITE_CODE;
        cur_lim     = RST_RO_LIMIT;
        sent        = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write above the read-only limit, then a byte after the frame is done
        send_byte(1'b1, 8'hFF);
        send_byte(1'b0, RST_WRITE_CODE);
        send_byte(1'b0, 8'h05);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hA5);
        send_byte(1'b0, 8'h5A);
        send_byte(1'b0, 8'h33);
        // read it back with trailing CRC
        send_byte(1'b1, 8'h00);
        send_byte(1'b0, RST_READ_CODE);
        send_byte(1'b0, 8'h05);
        repeat (WORD_BYTES + 1)
            send_byte(1'b0, 8'h00);
        // write to the read-only address
        send_byte(1'b1, 8'h00);
        send_byte(1'b0, RST_WRITE_CODE);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h01);
        send_byte(1'b0, 8'h02);
        send_byte(1'b0, 8'h03);
        send_byte(1'b0, 8'h04);
        // unknown command
        send_byte(1'b1, 8'h00);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h77);

        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            case (ph)
                0: apply_settings(1'b0, 8'h01, 8'h02, 8'h10, 8'h07);
                1: apply_settings(1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF);
                2: apply_settings(1'b1, 8'hFF, 8'h00, 8'h00, 8'h00);
                3: apply_settings(1'b1, 8'h5A, 8'h5A, 8'h80, 8'h31);
                4: apply_settings(1'b0, 8'hFF, 8'hFE, 8'hFE, 8'h1D);
                default:
                begin
                    cur_rd = 8'($urandom_range(0, 255));
                    cur_wr = ($urandom_range(0, 5) == 0) ? cur_rd : 8'($urandom_range(0, 255));
                    apply_settings(1'($urandom_range(0, 1)), cur_rd, cur_wr,
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            endcase
            goal = sent + 120;
            while (sent < goal)
                run_frame();
        end

        quiet = 1'b0;
        req.valid <= 1'b0;
        wait_cnt = 0;
        @(negedge clk);
        while (pending != 0 && wait_cnt < 20000)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_spi_slave_word_access_crc8 passed");
        else
            $display("tb_spi_slave_word_access_crc8 failed");
        $finish;
    end

endmodule
